### rtl/mlq_pkg.sv
// Shared types, constants and the microcode table of the three-level queue scheduler.
`timescale 1ns / 1ps

package mlq_pkg;

   // Default process capacity and field widths.
   localparam int MLQ_MAX_PROCS  = 64;
   localparam int BURST_W        = 16;
   localparam int QUANTUM_W      = 16;
   localparam int CLOCK_W        = 23;
   localparam int INDEX_W        = 6;
   localparam int TIME_W         = 22;
   localparam int TOTAL_W        = 28;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   // Quantum reset values.
   localparam logic [QUANTUM_W-1:0] FIRST_QUANTUM_RESET  = 16'd8;
   localparam logic [QUANTUM_W-1:0] SECOND_QUANTUM_RESET = 16'd16;

   // Configuration register indexes (address bit 2).
   localparam logic REG_FIRST_QUANTUM  = 1'b0;
   localparam logic REG_SECOND_QUANTUM = 1'b1;

   // Input word.
   typedef struct packed {
      logic [BURST_W-1:0] burst_time;
      logic               last_process;
   } mlq_req_type;

   // Result word.
   typedef struct packed {
      logic [INDEX_W-1:0] process_index;
      logic [TIME_W-1:0]  completion_time;
      logic [TIME_W-1:0]  waiting_time;
      logic [TOTAL_W-1:0] turnaround_total;
      logic [TOTAL_W-1:0] waiting_total;
      logic               final_result;
   } mlq_rsp_type;

   // Microprogram steps.
   typedef enum logic [3:0] {
      S_LOAD,
      S_P1_RD,
      S_P1_EX,
      S_P2_RD,
      S_P2_EX,
      S_P3_RD,
      S_P3_EX,
      S_EM_RD,
      S_EM_EX
   } step_type;

   // Sequencing modes of a control word.
   typedef enum logic [1:0] {
      J_NEXT,
      J_LOAD,
      J_LOOP
   } jump_type;

   // Slice granted by an execute step.
   typedef enum logic [1:0] {
      SLICE_Q1,
      SLICE_Q2,
      SLICE_FULL
   } slice_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic      load_en;
      logic      rd_en;
      logic      ex_en;
      logic      emit_en;
      slice_type slice_sel;
      logic      skip_zero;
      jump_type  jump;
      step_type  loop_target;
      step_type  exit_target;
   } mlq_uop_type;

   // Decoded controls from the sequencer to the datapath.
   typedef struct packed {
      logic      load_we;
      logic      rd_en;
      logic      ex_en;
      logic      emit_fire;
      logic      emit_last;
      logic      clear_set;
      slice_type slice_sel;
      logic      skip_zero;
   } mlq_ctrl_type;

   // Microcode table: load, three scheduling passes, then the emit pass.
   function automatic mlq_uop_type ucode_rom(input step_type step);
      mlq_uop_type uop;
      uop = '0;
      uop.slice_sel   = SLICE_Q1;
      uop.jump        = J_NEXT;
      uop.loop_target = S_LOAD;
      uop.exit_target = S_LOAD;
      unique case (step)
         S_LOAD: begin
            uop.load_en     = 1'b1;
            uop.jump        = J_LOAD;
            uop.exit_target = S_P1_RD;
         end
         S_P1_RD: begin
            uop.rd_en       = 1'b1;
            uop.exit_target = S_P1_EX;
         end
         S_P1_EX: begin
            uop.ex_en       = 1'b1;
            uop.slice_sel   = SLICE_Q1;
            uop.jump        = J_LOOP;
            uop.loop_target = S_P1_RD;
            uop.exit_target = S_P2_RD;
         end
         S_P2_RD: begin
            uop.rd_en       = 1'b1;
            uop.exit_target = S_P2_EX;
         end
         S_P2_EX: begin
            uop.ex_en       = 1'b1;
            uop.slice_sel   = SLICE_Q2;
            uop.skip_zero   = 1'b1;
            uop.jump        = J_LOOP;
            uop.loop_target = S_P2_RD;
            uop.exit_target = S_P3_RD;
         end
         S_P3_RD: begin
            uop.rd_en       = 1'b1;
            uop.exit_target = S_P3_EX;
         end
         S_P3_EX: begin
            uop.ex_en       = 1'b1;
            uop.slice_sel   = SLICE_FULL;
            uop.skip_zero   = 1'b1;
            uop.jump        = J_LOOP;
            uop.loop_target = S_P3_RD;
            uop.exit_target = S_EM_RD;
         end
         S_EM_RD: begin
            uop.rd_en       = 1'b1;
            uop.exit_target = S_EM_EX;
         end
         S_EM_EX: begin
            uop.emit_en     = 1'b1;
            uop.jump        = J_LOOP;
            uop.loop_target = S_EM_RD;
            uop.exit_target = S_LOAD;
         end
         default: begin
            uop.exit_target = S_LOAD;
         end
      endcase
      return uop;
   endfunction

endpackage

### rtl/mlq_sequencer.sv
// Microcode sequencer: step counter, process index and count, control decode.
`timescale 1ns / 1ps

module mlq_sequencer
   import mlq_pkg::*;
#(
   parameter int MAX_PROCS = MLQ_MAX_PROCS,
   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  logic                   slot_free,
   output mlq_ctrl_type           ctrl,
   output logic [IDX_W-1:0]       addr
);

   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   step_type         step_ff, step_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   mlq_uop_type      cw;
   logic             accept;
   logic             full;
   logic             stall;
   logic             at_end;

   // Step, index and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= S_LOAD;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   // Control word decode and next step.
   always_comb begin
      cw        = ucode_rom(step_ff);
      step_in   = step_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      req_ready = cw.load_en;
      accept    = req_valid && cw.load_en;
      full      = (count_ff == CNT_W'(MAX_PROCS));
      stall     = cw.emit_en && !slot_free;
      at_end    = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

      ctrl.load_we   = accept && !full;
      ctrl.rd_en     = cw.rd_en;
      ctrl.ex_en     = cw.ex_en;
      ctrl.emit_fire = cw.emit_en && slot_free;
      ctrl.emit_last = at_end;
      ctrl.clear_set = cw.emit_en && slot_free && at_end;
      ctrl.slice_sel = cw.slice_sel;
      ctrl.skip_zero = cw.skip_zero;

      // Loads go to the next free entry, passes walk the index.
      addr = cw.load_en ? count_ff[IDX_W-1:0] : idx_ff;

      if (accept && !full) begin
         count_in = count_ff + CNT_W'(1);
      end

      unique case (cw.jump)
         J_LOAD: begin
            if (accept && req_last) begin
               step_in = cw.exit_target;
            end
         end
         J_NEXT: begin
            step_in = cw.exit_target;
         end
         J_LOOP: begin
            if (!stall) begin
               if (at_end) begin
                  step_in = cw.exit_target;
                  idx_in  = '0;
               end else begin
                  step_in = cw.loop_target;
                  idx_in  = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            step_in = S_LOAD;
         end
      endcase

      // The set is done once its last result is handed off.
      if (ctrl.clear_set) begin
         count_in = '0;
      end
   end

`ifndef ASSERT_OFF
   a_last_starts_pass: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> (step_ff == S_P1_RD && idx_ff == '0))
      else $error("last word did not start the first pass at index zero");
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_set |=> (count_ff == '0 && step_ff == S_LOAD))
      else $error("set not cleared after the last result");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && full) |=> $stable(count_ff) || count_ff == '0)
      else $error("process count grew past capacity");
`endif

endmodule

### rtl/mlq_datapath.sv
// Datapath: burst and finish memories, shared clock, totals and result register.
`timescale 1ns / 1ps

module mlq_datapath
   import mlq_pkg::*;
#(
   parameter int MAX_PROCS = MLQ_MAX_PROCS,
   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mlq_ctrl_type           ctrl,
   input  logic [IDX_W-1:0]       addr,
   input  logic [BURST_W-1:0]     burst,
   input  logic [QUANTUM_W-1:0]   first_quantum,
   input  logic [QUANTUM_W-1:0]   second_quantum,
   output logic                   slot_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mlq_rsp_type            rsp_data
);

   logic [BURST_W-1:0] rem_mem  [MAX_PROCS];
   logic [BURST_W-1:0] orig_mem [MAX_PROCS];
   logic [CLOCK_W-1:0] fin_mem  [MAX_PROCS];

   logic [BURST_W-1:0] rem_rd_ff;
   logic [BURST_W-1:0] orig_rd_ff;
   logic [CLOCK_W-1:0] fin_rd_ff;

   logic [CLOCK_W-1:0] clock_ff, clock_in;
   logic [TOTAL_W-1:0] tat_sum_ff, tat_sum_in;
   logic [TOTAL_W-1:0] wait_sum_ff, wait_sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mlq_rsp_type        rsp_ff, rsp_in;

   logic [QUANTUM_W-1:0] slice;
   logic                 fits;
   logic                 run;
   logic [CLOCK_W-1:0]   clock_fit;
   logic [CLOCK_W-1:0]   clock_slice;
   logic [BURST_W-1:0]   rem_next;
   logic [TIME_W-1:0]    done;
   logic [TIME_W-1:0]    wait_v;

   // Slice execution on the word read in the previous step.
   always_comb begin
      slice       = (ctrl.slice_sel == SLICE_Q2) ? second_quantum : first_quantum;
      fits        = (ctrl.slice_sel == SLICE_FULL) || (rem_rd_ff <= slice);
      run         = ctrl.ex_en && !(ctrl.skip_zero && rem_rd_ff == '0);
      clock_fit   = clock_ff + CLOCK_W'(rem_rd_ff);
      clock_slice = clock_ff + CLOCK_W'(slice);
      rem_next    = fits ? '0 : (rem_rd_ff - slice);
      clock_in    = clock_ff;
      if (run) begin
         clock_in = fits ? clock_fit : clock_slice;
      end
      if (ctrl.clear_set) begin
         clock_in = '0;
      end
   end

   // Burst and finish memories: bursts written on load and after each slice, finish times when a process completes.
   always_ff @(posedge clock) begin
      if (ctrl.load_we) begin
         rem_mem[addr]  <= burst;
         orig_mem[addr] <= burst;
      end else if (run) begin
         rem_mem[addr] <= rem_next;
      end
      if (run && fits) begin
         fin_mem[addr] <= clock_fit;
      end
      if (ctrl.rd_en) begin
         rem_rd_ff  <= rem_mem[addr];
         orig_rd_ff <= orig_mem[addr];
         fin_rd_ff  <= fin_mem[addr];
      end
   end

   // Result assembly and running totals.
   always_comb begin
      done         = fin_rd_ff[TIME_W-1:0];
      wait_v       = done - TIME_W'(orig_rd_ff);
      tat_sum_in   = tat_sum_ff;
      wait_sum_in  = wait_sum_ff;
      rsp_in       = rsp_ff;
      slot_free    = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctrl.emit_fire) begin
         tat_sum_in              = tat_sum_ff + TOTAL_W'(done);
         wait_sum_in             = wait_sum_ff + TOTAL_W'(wait_v);
         rsp_in.process_index    = INDEX_W'(addr);
         rsp_in.completion_time  = done;
         rsp_in.waiting_time     = wait_v;
         rsp_in.turnaround_total = tat_sum_in;
         rsp_in.waiting_total    = wait_sum_in;
         rsp_in.final_result     = ctrl.emit_last;
         rsp_valid_in            = 1'b1;
      end
      if (ctrl.clear_set) begin
         tat_sum_in  = '0;
         wait_sum_in = '0;
      end
   end

   // Clock, totals and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff     <= '0;
         tat_sum_ff   <= '0;
         wait_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clock_ff     <= clock_in;
         tat_sum_ff   <= tat_sum_in;
         wait_sum_ff  <= wait_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_emit_only_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit_fire |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a word not yet taken");
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit_fire |=> rsp_valid_ff)
      else $error("emitted result not presented");
   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_set |=> (clock_ff == '0 && tat_sum_ff == '0 && wait_sum_ff == '0))
      else $error("clock or totals not cleared after the set");
`endif

endmodule

### rtl/multilevel_queue_completion_times_core.sv
// Top level: configuration registers, microcode sequencer and scheduling datapath.
// Loading: one input word per cycle while the core is in its load step; the word marked last starts scheduling.
// Scheduling: a read step, then an update step, per stored process in each of three levels,
// as the burst memories are single-port; the emit pass follows the third level.
// Emit: a read step, then an emit step per result; the emit step waits while the output is stalled.
// Reset (synchronous) clears control, count, clock, totals and valid; quanta go to 8 and 16.
`timescale 1ns / 1ps

module multilevel_queue_completion_times_core
   import mlq_pkg::*;
#(
   parameter int MAX_PROCS = MLQ_MAX_PROCS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mlq_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mlq_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

   logic [QUANTUM_W-1:0] q1_ff, q1_in;
   logic [QUANTUM_W-1:0] q2_ff, q2_in;
   logic                 csr_write;
   mlq_ctrl_type         ctrl;
   logic [IDX_W-1:0]     addr;
   logic                 slot_free;

   // Configuration writes complete in the access cycle.
   always_comb begin
      pready    = 1'b1;
      csr_write = psel && penable && pwrite && pready;
      q1_in     = q1_ff;
      q2_in     = q2_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_FIRST_QUANTUM:  q1_in = pwdata[QUANTUM_W-1:0];
            REG_SECOND_QUANTUM: q2_in = pwdata[QUANTUM_W-1:0];
            default:            q1_in = q1_ff;
         endcase
      end
      prdata = (paddr[2] == REG_SECOND_QUANTUM) ? CSR_DATA_W'(q2_ff) : CSR_DATA_W'(q1_ff);
   end

   // Quantum registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         q1_ff <= FIRST_QUANTUM_RESET;
         q2_ff <= SECOND_QUANTUM_RESET;
      end else begin
         q1_ff <= q1_in;
         q2_ff <= q2_in;
      end
   end

   // Sequencer.
   mlq_sequencer #(
      .MAX_PROCS (MAX_PROCS)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_process),
      .req_ready (req_ready),
      .slot_free (slot_free),
      .ctrl      (ctrl),
      .addr      (addr)
   );

   // Datapath.
   mlq_datapath #(
      .MAX_PROCS (MAX_PROCS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .addr           (addr),
      .burst          (req_data.burst_time),
      .first_quantum  (q1_ff),
      .second_quantum (q2_ff),
      .slot_free      (slot_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule
